// ===== rtl/lik_pkg.sv =====
// ----------------------------------------------------------------------------
// lik_pkg: shared types and constants for the leg inverse kinematics block
// Widths, stage counts, register codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package lik_pkg;

  // pipeline depths
  localparam int SQRT_STAGES  = 31;
  localparam int CORDIC_STEPS = 20;
  localparam int NORM_STAGES  = 3;
  localparam int CORDIC_LAT   = NORM_STAGES + CORDIC_STEPS + 1;

  // datapath widths
  localparam int ROOT_IN_W = 2 * SQRT_STAGES;  // radicand
  localparam int ROOT_W    = SQRT_STAGES;      // root
  localparam int XIN_W     = 33;               // signed x operand of atan2
  localparam int NORM_TOP  = 40;               // operands scaled up to 2^40
  localparam int NORM_W    = NORM_TOP + 1;
  localparam int CW        = 45;               // CORDIC x/y
  localparam int ZW        = 25;               // CORDIC angle accumulator
  localparam int ANG_W     = 24;               // 0..180 degrees, Q16

  localparam logic [ANG_W-1:0] DEG180_Q16 = 24'd11796480;
  localparam logic [ANG_W-1:0] DEG90_Q16  = 24'd5898240;
  localparam logic [ANG_W-1:0] HALF_Q16   = 24'd32768;
  localparam logic [7:0]       DEG_MAX    = 8'd180;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 2'd2;
  localparam logic [8:0] UPPER_LINK_RESET = 9'd60;
  localparam logic [8:0] LOWER_LINK_RESET = 9'd100;
  localparam logic [9:0] MIN_RADIUS_RESET = 10'd30;

  typedef struct packed {
    logic [2:0] leg;
    logic [7:0] rot;
    logic       imm;
  } side_t;

  // item context leaving the front end
  typedef struct packed {
    side_t              side;
    logic               okp;
    logic               reach;
    logic signed [10:0] h;
    logic [9:0]         rad;
    logic signed [22:0] x1;
    logic signed [22:0] x3;
  } mid_t;

  typedef struct packed {
    side_t side;
    logic  okp;
    logic  reach;
  } tail_t;

  typedef struct packed {
    logic [2:0] leg;
    logic [7:0] moving;
    logic [7:0] central;
    logic [7:0] rot;
    logic       imm;
    logic       ok;
    logic       reach;
  } res_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [ZW-1:0] atan_q16(input int step);
    logic [ZW-1:0] a;
    case (step)
      0:  a = 25'd2949120;
      1:  a = 25'd1740967;
      2:  a = 25'd919879;
      3:  a = 25'd466945;
      4:  a = 25'd234379;
      5:  a = 25'd117304;
      6:  a = 25'd58666;
      7:  a = 25'd29335;
      8:  a = 25'd14668;
      9:  a = 25'd7334;
      10: a = 25'd3667;
      11: a = 25'd1833;
      12: a = 25'd917;
      13: a = 25'd458;
      14: a = 25'd229;
      15: a = 25'd115;
      16: a = 25'd57;
      17: a = 25'd29;
      18: a = 25'd14;
      19: a = 25'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/lik_front.sv =====
// ----------------------------------------------------------------------------
// lik_front: five-stage front end
// Squares, reach check, law-of-cosines terms and radicands for both roots.
// ----------------------------------------------------------------------------
module lik_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           target_valid,
  input  logic signed [10:0]             height,
  input  logic [9:0]                     radius,
  input  lik_pkg::side_t                 side,
  input  logic [8:0]                     upper_link,
  input  logic [8:0]                     lower_link,
  input  logic [9:0]                     min_reach,
  output logic                           mid_valid,
  output lik_pkg::mid_t                  mid,
  output logic [lik_pkg::ROOT_IN_W-1:0]  n_upper,
  output logic [lik_pkg::ROOT_IN_W-1:0]  n_knee
);

  // stage 1: squares
  logic                v1;
  lik_pkg::side_t      side1;
  logic signed [10:0]  h1;
  logic [9:0]          rad1;
  logic [20:0]         hsq1;
  logic [19:0]         radsq1;
  logic [17:0]         l1sq1;
  logic [17:0]         l2sq1;
  logic [19:0]         sumsq1;
  logic [21:0]         hhsq1;
  logic                minok1;
  logic                hneg1;

  logic [9:0]          link_sum;
  logic signed [11:0]  hh;
  logic signed [21:0]  hw;
  logic signed [21:0]  hhw;
  logic signed [21:0]  hsq_w;
  logic signed [21:0]  hhsq_w;
  logic [19:0]         radsq_w;
  logic [17:0]         l1sq_w;
  logic [17:0]         l2sq_w;
  logic [19:0]         sumsq_w;

  assign link_sum = {1'b0, upper_link} + {1'b0, lower_link};
  assign hh       = $signed({height[10], height}) + $signed({3'b000, lower_link});
  assign hw       = $signed({{11{height[10]}}, height});
  assign hhw      = $signed({{10{hh[11]}}, hh});
  assign hsq_w    = hw * hw;
  assign hhsq_w   = hhw * hhw;
  assign radsq_w  = radius * radius;
  assign l1sq_w   = upper_link * upper_link;
  assign l2sq_w   = lower_link * lower_link;
  assign sumsq_w  = link_sum * link_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= target_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1  <= side;
      h1     <= height;
      rad1   <= radius;
      hsq1   <= hsq_w[20:0];
      radsq1 <= radsq_w;
      l1sq1  <= l1sq_w;
      l2sq1  <= l2sq_w;
      sumsq1 <= sumsq_w;
      hhsq1  <= $unsigned(hhsq_w);
      minok1 <= radius >= min_reach;
      hneg1  <= height[10];
    end
  end

  // stage 2: distance squared and reach
  logic                v2;
  lik_pkg::side_t      side2;
  logic signed [10:0]  h2;
  logic [9:0]          rad2;
  logic [20:0]         r2_2;
  logic [17:0]         l1sq2;
  logic [17:0]         l2sq2;
  logic                reach2;

  logic [20:0]         r2_w;
  logic [22:0]         rr_w;

  assign r2_w = {1'b0, hsq1[19:0]} + {1'b0, radsq1} + {hsq1[20], 20'd0};
  assign rr_w = {3'b000, radsq1} + {1'b0, hhsq1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2  <= side1;
      h2     <= h1;
      rad2   <= rad1;
      r2_2   <= r2_w;
      l1sq2  <= l1sq1;
      l2sq2  <= l2sq1;
      // foot below the shoulder must stay outside the lower link's circle
      reach2 <= minok1 && ({1'b0, sumsq1} > r2_w) &&
                (!hneg1 || (rr_w >= {5'd0, l2sq1}));
    end
  end

  // stage 3: cosine-law numerators and squared denominators
  logic                v3;
  lik_pkg::side_t      side3;
  logic signed [10:0]  h3;
  logic [9:0]          rad3;
  logic                reach3;
  logic signed [22:0]  x1_3;
  logic signed [22:0]  x3_3;
  logic [40:0]         d1_3;
  logic [37:0]         d3_3;
  logic                nz3;

  logic signed [22:0]  x1_w;
  logic signed [22:0]  x3_w;
  logic [38:0]         p1_w;
  logic [35:0]         p3_w;

  assign x1_w = $signed({2'b00, r2_2}) + $signed({5'd0, l1sq2}) - $signed({5'd0, l2sq2});
  assign x3_w = $signed({5'd0, l1sq2}) + $signed({5'd0, l2sq2}) - $signed({2'b00, r2_2});
  assign p1_w = r2_2 * l1sq2;
  assign p3_w = l1sq2 * l2sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3  <= side2;
      h3     <= h2;
      rad3   <= rad2;
      reach3 <= reach2;
      x1_3   <= x1_w;
      x3_3   <= x3_w;
      d1_3   <= {p1_w, 2'b00};
      d3_3   <= {p3_w, 2'b00};
      nz3    <= (r2_2 != '0) && (upper_link != '0) && (lower_link != '0);
    end
  end

  // stage 4: numerator squares
  logic                v4;
  lik_pkg::side_t      side4;
  logic signed [10:0]  h4;
  logic [9:0]          rad4;
  logic                reach4;
  logic signed [22:0]  x1_4;
  logic signed [22:0]  x3_4;
  logic [40:0]         d1_4;
  logic [37:0]         d3_4;
  logic [43:0]         sq1_4;
  logic [43:0]         sq3_4;
  logic                nz4;

  logic [21:0]         a1_w;
  logic [21:0]         a3_w;
  logic [43:0]         sq1_w;
  logic [43:0]         sq3_w;

  assign a1_w  = x1_3[22] ? 22'(-x1_3) : 22'(x1_3);
  assign a3_w  = x3_3[22] ? 22'(-x3_3) : 22'(x3_3);
  assign sq1_w = a1_w * a1_w;
  assign sq3_w = a3_w * a3_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4  <= side3;
      h4     <= h3;
      rad4   <= rad3;
      reach4 <= reach3;
      x1_4   <= x1_3;
      x3_4   <= x3_3;
      d1_4   <= d1_3;
      d3_4   <= d3_3;
      sq1_4  <= sq1_w;
      sq3_4  <= sq3_w;
      nz4    <= nz3;
    end
  end

  // stage 5: domain check and radicands (sine terms, scaled by 2^20)
  logic [43:0] diff1_w;
  logic [43:0] diff3_w;
  logic        okp_w;

  assign diff1_w = {3'b000, d1_4} - sq1_4;
  assign diff3_w = {6'd0, d3_4} - sq3_4;
  assign okp_w   = nz4 && (sq1_4 <= {3'b000, d1_4}) && (sq3_4 <= {6'd0, d3_4});

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid.side  <= side4;
      mid.okp   <= okp_w;
      mid.reach <= reach4;
      mid.h     <= h4;
      mid.rad   <= rad4;
      mid.x1    <= x1_4;
      mid.x3    <= x3_4;
      n_upper   <= {diff1_w[41:0], 20'd0};
      n_knee    <= {diff3_w[41:0], 20'd0};
    end
  end

endmodule

// ===== rtl/lik_sqrt.sv =====
// ----------------------------------------------------------------------------
// lik_sqrt: pipelined integer square root
// Digit recurrence, one result bit per stage, truncating.
// ----------------------------------------------------------------------------
module lik_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lik_pkg::ROOT_IN_W-1:0] n,
  output logic [lik_pkg::ROOT_W-1:0]    root
);

  logic [lik_pkg::ROOT_IN_W-1:0] rem_q [lik_pkg::SQRT_STAGES];
  logic [lik_pkg::ROOT_IN_W-1:0] res_q [lik_pkg::SQRT_STAGES];

  for (genvar g = 0; g < lik_pkg::SQRT_STAGES; g++) begin : g_stage
    localparam logic [lik_pkg::ROOT_IN_W-1:0] BIT =
      lik_pkg::ROOT_IN_W'(1) << (lik_pkg::ROOT_IN_W - 2 - 2 * g);

    logic [lik_pkg::ROOT_IN_W-1:0] rem_in;
    logic [lik_pkg::ROOT_IN_W-1:0] res_in;
    logic [lik_pkg::ROOT_IN_W-1:0] trial;

    if (g == 0) begin : g_first
      assign rem_in = n;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign res_in = res_q[g-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[g] <= rem_in - trial;
          res_q[g] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[g] <= rem_in;
          res_q[g] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[lik_pkg::SQRT_STAGES-1][lik_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/lik_cordic.sv =====
// ----------------------------------------------------------------------------
// lik_cordic: pipelined atan2 in degrees, Q16
// Three normalising stages, twenty vectoring stages, one fold stage.
// ----------------------------------------------------------------------------
module lik_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lik_pkg::ROOT_W-1:0]        y,
  input  logic signed [lik_pkg::XIN_W-1:0]  x,
  output logic [lik_pkg::ANG_W-1:0]         angle
);

  localparam int NW = lik_pkg::NORM_W;

  // true when m can be doubled amt times and stay below 2^40
  function automatic logic fits(input logic [NW-1:0] m, input int amt);
    return (m >> (lik_pkg::NORM_TOP - amt)) == '0;
  endfunction

  // normalise stage a: fold to the right half-plane, shift by 32 / 16
  logic [NW-1:0] ax, ay, sa_x, sa_y;
  logic [NW-1:0] na_x, na_y;
  logic          na_l;

  always_comb begin
    ax   = x[lik_pkg::XIN_W-1] ? NW'(-x) : NW'(x);
    ay   = NW'(y);
    sa_x = ax;
    sa_y = ay;
    if (fits(sa_x | sa_y, 32)) begin
      sa_x = sa_x << 32;
      sa_y = sa_y << 32;
    end
    if (fits(sa_x | sa_y, 16)) begin
      sa_x = sa_x << 16;
      sa_y = sa_y << 16;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_x <= sa_x;
      na_y <= sa_y;
      na_l <= x[lik_pkg::XIN_W-1];
    end
  end

  // stage b: shift by 8 / 4
  logic [NW-1:0] sb_x, sb_y, nb_x, nb_y;
  logic          nb_l;

  always_comb begin
    sb_x = na_x;
    sb_y = na_y;
    if (fits(sb_x | sb_y, 8)) begin
      sb_x = sb_x << 8;
      sb_y = sb_y << 8;
    end
    if (fits(sb_x | sb_y, 4)) begin
      sb_x = sb_x << 4;
      sb_y = sb_y << 4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nb_x <= sb_x;
      nb_y <= sb_y;
      nb_l <= na_l;
    end
  end

  // stage c: shift by 2 / 1, then the last doubling past 2^40
  logic [NW-1:0] sc_x, sc_y, nc_x, nc_y;
  logic          nc_l;

  always_comb begin
    sc_x = nb_x;
    sc_y = nb_y;
    if (fits(sc_x | sc_y, 2)) begin
      sc_x = sc_x << 2;
      sc_y = sc_y << 2;
    end
    if (fits(sc_x | sc_y, 1)) begin
      sc_x = sc_x << 1;
      sc_y = sc_y << 1;
    end
    sc_x = sc_x << 1;
    sc_y = sc_y << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nc_x <= sc_x;
      nc_y <= sc_y;
      nc_l <= nb_l;
    end
  end

  // vectoring stages
  logic signed [lik_pkg::CW-1:0] cx_q [lik_pkg::CORDIC_STEPS];
  logic signed [lik_pkg::CW-1:0] cy_q [lik_pkg::CORDIC_STEPS];
  logic signed [lik_pkg::ZW-1:0] cz_q [lik_pkg::CORDIC_STEPS];
  logic                          cl_q [lik_pkg::CORDIC_STEPS];

  for (genvar g = 0; g < lik_pkg::CORDIC_STEPS; g++) begin : g_step
    localparam logic signed [lik_pkg::ZW-1:0] ATAN = $signed(lik_pkg::atan_q16(g));

    logic signed [lik_pkg::CW-1:0] x_in, y_in, xs, ys;
    logic signed [lik_pkg::ZW-1:0] z_in;
    logic                          l_in;

    if (g == 0) begin : g_first
      assign x_in = $signed({{(lik_pkg::CW - NW){1'b0}}, nc_x});
      assign y_in = $signed({{(lik_pkg::CW - NW){1'b0}}, nc_y});
      assign z_in = '0;
      assign l_in = nc_l;
    end else begin : g_next
      assign x_in = cx_q[g-1];
      assign y_in = cy_q[g-1];
      assign z_in = cz_q[g-1];
      assign l_in = cl_q[g-1];
    end

    // arithmetic shift: rounds toward minus infinity
    assign xs = x_in >>> g;
    assign ys = y_in >>> g;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in > 0) begin
          cx_q[g] <= x_in + ys;
          cy_q[g] <= y_in - xs;
          cz_q[g] <= z_in + ATAN;
        end else begin
          cx_q[g] <= x_in - ys;
          cy_q[g] <= y_in + xs;
          cz_q[g] <= z_in - ATAN;
        end
        cl_q[g] <= l_in;
      end
    end
  end

  // fold: clamp to the first quadrant, mirror for negative x
  logic signed [lik_pkg::ZW-1:0] z_last;
  logic [lik_pkg::ANG_W-1:0]     zc;

  assign z_last = cz_q[lik_pkg::CORDIC_STEPS-1];

  always_comb begin
    if (z_last[lik_pkg::ZW-1]) begin
      zc = '0;
    end else if (z_last > $signed({1'b0, lik_pkg::DEG90_Q16})) begin
      zc = lik_pkg::DEG90_Q16;
    end else begin
      zc = z_last[lik_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= cl_q[lik_pkg::CORDIC_STEPS-1] ? lik_pkg::DEG180_Q16 - zc : zc;
    end
  end

endmodule

// ===== rtl/leg_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// leg_inverse_kinematics: two-link leg joint angles with reach check
// Fully pipelined; one leg target in, one joint-angle result out.
// ----------------------------------------------------------------------------
// Usage
//   Target channel: height, radius, rotation, leg_index, immediate_move with
//   target_valid / target_stall. A transfer happens on a rising edge with
//   valid high and stall low.
//   Result channel: leg_number, moving_angle, central_angle, rotation_out,
//   immediate_out, angles_ok, reach_ok with result_valid / result_stall.
//   Config channel: cfg_valid / cfg_ready, cfg_index, cfg_data. Index 0 upper
//   link, 1 lower link, 2 minimum radius; other indices are dropped. Write
//   only while no target is in flight.
// Timing
//   61 register stages: 5 front-end, 31 square-root, 24 CORDIC, output
//   register. Throughput one target per cycle while the skid entry is
//   empty, set by the one-bit-per-stage root and one-step-per-stage CORDIC
//   pipelines.
// Reset (rst, synchronous) empties the pipe and loads link lengths 60/100
//   and minimum radius 30.
// A stalled result is held; the following item parks in a one-entry skid
//   register and only then is target_stall raised, for as long as it is full.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics (
  input  logic                             clk,
  input  logic                             rst,
  // targets
  input  logic                             target_valid,
  output logic                             target_stall,
  input  logic signed [10:0]               height,
  input  logic [9:0]                       radius,
  input  logic [7:0]                       rotation,
  input  logic [2:0]                       leg_index,
  input  logic                             immediate_move,
  // results
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [2:0]                       leg_number,
  output logic [7:0]                       moving_angle,
  output logic [7:0]                       central_angle,
  output logic [7:0]                       rotation_out,
  output logic                             immediate_out,
  output logic                             angles_ok,
  output logic                             reach_ok,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lik_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lik_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // ---- configuration registers --------------------------------------------
  logic [8:0] upper_link;
  logic [8:0] lower_link;
  logic [9:0] min_reach;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link <= lik_pkg::UPPER_LINK_RESET;
      lower_link <= lik_pkg::LOWER_LINK_RESET;
      min_reach  <= lik_pkg::MIN_RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lik_pkg::REG_UPPER_LINK: upper_link <= cfg_data[8:0];
        lik_pkg::REG_LOWER_LINK: lower_link <= cfg_data[8:0];
        lik_pkg::REG_MIN_RADIUS: min_reach  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- pipeline enable ----------------------------------------------------
  // The whole pipe moves together; it only stops when the skid entry is
  // occupied, so the stall never reaches back combinationally.
  logic skid_v;
  logic en;

  assign en           = !skid_v;
  assign target_stall = skid_v;

  // ---- front end: squares, reach, radicands -------------------------------
  lik_pkg::side_t side_in;
  logic           mid_valid;
  lik_pkg::mid_t  mid;
  logic [lik_pkg::ROOT_IN_W-1:0] n_upper, n_knee;

  assign side_in = '{leg: leg_index, rot: rotation, imm: immediate_move};

  lik_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .target_valid (target_valid),
    .height       (height),
    .radius       (radius),
    .side         (side_in),
    .upper_link   (upper_link),
    .lower_link   (lower_link),
    .min_reach    (min_reach),
    .mid_valid    (mid_valid),
    .mid          (mid),
    .n_upper      (n_upper),
    .n_knee       (n_knee)
  );

  // ---- square roots (sine terms of both cosine-law angles) ----------------
  logic [lik_pkg::ROOT_W-1:0] s_upper, s_knee;

  lik_sqrt u_sqrt_upper (.clk(clk), .en(en), .n(n_upper), .root(s_upper));
  lik_sqrt u_sqrt_knee  (.clk(clk), .en(en), .n(n_knee),  .root(s_knee));

  // context travels beside the roots
  lik_pkg::mid_t mid_q  [lik_pkg::SQRT_STAGES];
  logic          midv_q [lik_pkg::SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lik_pkg::SQRT_STAGES; i++) begin
        midv_q[i] <= 1'b0;
      end
    end else if (en) begin
      midv_q[0] <= mid_valid;
      for (int i = 1; i < lik_pkg::SQRT_STAGES; i++) begin
        midv_q[i] <= midv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_q[0] <= mid;
      for (int i = 1; i < lik_pkg::SQRT_STAGES; i++) begin
        mid_q[i] <= mid_q[i-1];
      end
    end
  end

  // ---- three atan2 lanes --------------------------------------------------
  // foot direction atan2(rad, h); shoulder term atan2(s1, x1);
  // knee term atan2(s3, x3). The x terms are scaled by 2^10 to match the roots.
  lik_pkg::mid_t mid_end;
  logic [lik_pkg::ANG_W-1:0] ang_foot, ang_upper, ang_knee;

  assign mid_end = mid_q[lik_pkg::SQRT_STAGES-1];

  lik_cordic u_cordic_foot (
    .clk   (clk),
    .en    (en),
    .y     ({{(lik_pkg::ROOT_W - 10){1'b0}}, mid_end.rad}),
    .x     ($signed({{(lik_pkg::XIN_W - 11){mid_end.h[10]}}, mid_end.h})),
    .angle (ang_foot)
  );

  lik_cordic u_cordic_upper (
    .clk   (clk),
    .en    (en),
    .y     (s_upper),
    .x     ($signed({mid_end.x1, 10'd0})),
    .angle (ang_upper)
  );

  lik_cordic u_cordic_knee (
    .clk   (clk),
    .en    (en),
    .y     (s_knee),
    .x     ($signed({mid_end.x3, 10'd0})),
    .angle (ang_knee)
  );

  lik_pkg::tail_t tail_q  [lik_pkg::CORDIC_LAT];
  logic           tailv_q [lik_pkg::CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lik_pkg::CORDIC_LAT; i++) begin
        tailv_q[i] <= 1'b0;
      end
    end else if (en) begin
      tailv_q[0] <= midv_q[lik_pkg::SQRT_STAGES-1];
      for (int i = 1; i < lik_pkg::CORDIC_LAT; i++) begin
        tailv_q[i] <= tailv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_q[0] <= '{side: mid_end.side, okp: mid_end.okp, reach: mid_end.reach};
      for (int i = 1; i < lik_pkg::CORDIC_LAT; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  // ---- degree rounding and saturation -------------------------------------
  lik_pkg::tail_t tail_end;
  logic           fin_v;
  logic [25:0]    bsum;
  logic [24:0]    csum;
  logic [9:0]     bdeg;
  logic [8:0]     cdeg;
  logic [8:0]     cdeg_sat;
  lik_pkg::res_t  fin;

  assign tail_end = tail_q[lik_pkg::CORDIC_LAT-1];
  assign fin_v    = tailv_q[lik_pkg::CORDIC_LAT-1];
  assign bsum     = 26'(ang_upper) + 26'(ang_foot) + 26'(lik_pkg::HALF_Q16);
  assign csum     = 25'(ang_knee) + 25'(lik_pkg::HALF_Q16);
  assign bdeg     = bsum[25:16];
  assign cdeg     = csum[24:16];
  assign cdeg_sat = (cdeg > 9'(lik_pkg::DEG_MAX)) ? 9'(lik_pkg::DEG_MAX) : cdeg;

  always_comb begin
    fin.leg   = tail_end.side.leg;
    fin.rot   = tail_end.side.rot;
    fin.imm   = tail_end.side.imm;
    fin.reach = tail_end.reach;
    if (!tail_end.okp) begin
      // degenerate geometry or target outside the cosine domain
      fin.moving  = '0;
      fin.central = '0;
      fin.ok      = 1'b0;
    end else begin
      fin.moving = 8'(9'(lik_pkg::DEG_MAX) - cdeg_sat);
      if (bdeg > 10'(lik_pkg::DEG_MAX)) begin
        fin.central = lik_pkg::DEG_MAX;
        fin.ok      = 1'b0;
      end else begin
        fin.central = bdeg[7:0];
        fin.ok      = 1'b1;
      end
    end
  end

  // ---- output register and skid entry -------------------------------------
  lik_pkg::res_t out_d;
  lik_pkg::res_t skid_d;
  logic          out_v;
  logic          take;

  assign take = out_v && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!out_v || take) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (fin_v) begin
      if (!out_v || take) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (take) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!out_v || take) begin
        out_d <= skid_d;
      end
    end else if (fin_v) begin
      if (!out_v || take) begin
        out_d <= fin;
      end else begin
        skid_d <= fin;
      end
    end
  end

  assign result_valid   = out_v;
  assign leg_number     = out_d.leg;
  assign moving_angle   = out_d.moving;
  assign central_angle  = out_d.central;
  assign rotation_out   = out_d.rot;
  assign immediate_out  = out_d.imm;
  assign angles_ok      = out_d.ok;
  assign reach_ok       = out_d.reach;

`ifndef SYNTH
  // the skid entry is only ever used behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid entry full with no result on offer");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(result_valid && result_stall))
    else $error("skid entry filled while the result was not held");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && angles_ok |->
      (central_angle <= lik_pkg::DEG_MAX) && (moving_angle <= lik_pkg::DEG_MAX))
    else $error("valid angles outside 0..180");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !angles_ok && (central_angle != lik_pkg::DEG_MAX) |->
      (moving_angle == 8'd0) && (central_angle == 8'd0))
    else $error("undefined angles not cleared");
`endif

endmodule
